>>> design/rbdts_pkg.sv
// shared types and constants for the transmit ring buffer dma scheduler
package rbdts_pkg;

  localparam int unsigned BUFFER_DEPTH = 512;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned RIDX_W  = 9;
  localparam int unsigned SSTART_W = 9;
  localparam int unsigned SLEN_W  = 10;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 2'd0,
    CMD_DONE = 2'd1,
    CMD_READ = 2'd2
  } cmd_e;

  // per-item result of the pointer scheduler
  typedef struct packed {
    logic                byte_accepted;
    logic                dma_start;
    logic [SSTART_W-1:0] segment_start;
    logic [SLEN_W-1:0]   segment_length;
  } sched_res_t;

endpackage

>>> design/rbdts_ram.sv
// generic single-port synchronous ram with registered read
module rbdts_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/rbdts_sched.sv
// head, tail and busy registers with the dma segment start logic
module rbdts_sched #(
  parameter int unsigned Depth = rbdts_pkg::BUFFER_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  rbdts_pkg::cmd_e          cmd_i,
  input  logic                     eom_i,
  output rbdts_pkg::sched_res_t    res_o,
  output logic                     wr_en_o,
  output logic [$clog2(Depth)-1:0] wr_addr_o
);
  import rbdts_pkg::*;

  localparam int unsigned IW = $clog2(Depth);
  localparam int unsigned LW = $clog2(Depth + 1);

  logic [IW-1:0] head_q, head_d, tail_q, tail_d;
  logic          busy_q, busy_d;
  logic [LW-1:0] alen_q, alen_d;

  logic [IW-1:0] head_nxt, h_eff, t_eff;
  logic [LW-1:0] tail_sum, seg_len;
  logic          is_push, is_done, full, attempt, start;

  always_comb begin
    is_push  = (cmd_i == CMD_PUSH);
    is_done  = (cmd_i == CMD_DONE) && busy_q;
    head_nxt = (head_q == IW'(Depth - 1)) ? '0 : head_q + 1'b1;
    full     = (head_nxt == tail_q);
    h_eff    = (is_push && !full) ? head_nxt : head_q;
    // tail plus length never passes the buffer end
    tail_sum = LW'(tail_q) + alen_q;
    t_eff    = is_done ? ((tail_sum == LW'(Depth)) ? '0 : tail_sum[IW-1:0]) : tail_q;
    attempt  = (is_push && eom_i) || is_done;
    start    = attempt && (is_done || !busy_q) && (h_eff != t_eff);
    seg_len  = (h_eff > t_eff) ? LW'(h_eff - t_eff) : LW'(Depth) - LW'(t_eff);

    res_o.byte_accepted  = is_push && !full;
    res_o.dma_start      = start;
    res_o.segment_start  = start ? SSTART_W'(t_eff) : '0;
    res_o.segment_length = start ? SLEN_W'(seg_len) : '0;

    head_d = head_q;
    tail_d = tail_q;
    busy_d = busy_q;
    alen_d = alen_q;
    if (accept_i) begin
      head_d = h_eff;
      tail_d = t_eff;
      if (is_done) begin
        busy_d = 1'b0;
      end
      if (start) begin
        busy_d = 1'b1;
        alen_d = seg_len;
      end
    end
  end

  assign wr_en_o   = accept_i && is_push && !full;
  assign wr_addr_o = head_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      busy_q <= 1'b0;
      alen_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      busy_q <= busy_d;
      alen_q <= alen_d;
    end
  end

endmodule

>>> design/ring_buffer_dma_tx_scheduler.sv
// top level of the transmit ring buffer with dma segment scheduler
// usage:
//   input stream: tuser carries the command (push, dma done, read), tdata the
//   byte to push and the slot to read, tlast marks the last byte of a message.
//   every input item yields exactly one output item carrying byte_accepted,
//   dma_start, segment_start, segment_length and read_data.
// throughput: one item per cycle while tready stays high; the result is valid
//   in the cycle after acceptance. the ring store is a single-port ram with a
//   registered read, so a push writes and a read fetches through the same
//   port, one access per item; head, tail and busy update in the same cycle.
// stall: the result sits in an output register; while the receiver holds
//   tready low the register and the ram read data hold, and the input side
//   only takes a new item in a cycle where the result is being taken.
// reset: head, tail, busy and the recorded length clear, the output goes
//   invalid. the ram is not cleared and needs no clearing pass: a slot read
//   before it has ever been written returns whatever it holds.
module ring_buffer_dma_tx_scheduler #(
  parameter int unsigned BufferDepth = rbdts_pkg::BUFFER_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // data_byte[7:0], read_index[16:8], zero pad
  input  logic        s_axis_tlast_i,  // end_of_message
  input  logic [1:0]  s_axis_tuser_i,  // command[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o   // byte_accepted[0], dma_start[1],
                                       // segment_start[10:2], segment_length[20:11],
                                       // read_data[28:21], zero pad
);
  import rbdts_pkg::*;

  localparam int unsigned IW = $clog2(BufferDepth);

  // input unpacking
  cmd_e              cmd;
  logic [BYTE_W-1:0] data_byte;
  logic [RIDX_W-1:0] read_index;
  logic              in_acc;

  assign cmd        = cmd_e'(s_axis_tuser_i);
  assign data_byte  = s_axis_tdata_i[7:0];
  assign read_index = s_axis_tdata_i[16:8];

  // take a new item whenever the output register is free or being emptied
  assign s_axis_tready_o = !m_axis_tvalid_o || m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // read index wraps modulo the depth: the quotient comes from a multiply by
  // a scaled reciprocal of the depth, exact for every 9-bit index
  localparam int unsigned RED_SH  = RIDX_W + $clog2(BufferDepth);
  localparam int unsigned RED_MUL = ((1 << RED_SH) + BufferDepth - 1) / BufferDepth;
  localparam int unsigned RED_W   = 2 * RIDX_W + 2;

  logic [RED_W-1:0]  rprod;
  logic [RIDX_W-1:0] rquo;
  logic [RIDX_W-1:0] rem;
  logic [IW-1:0]     ridx;

  always_comb begin
    rprod = RED_W'(read_index) * RED_W'(RED_MUL);
    rquo  = RIDX_W'(rprod >> RED_SH);
    rem   = read_index - RIDX_W'(32'(rquo) * BufferDepth);
    ridx  = IW'(rem);
  end

  // pointer and segment scheduling
  sched_res_t    sres;
  logic          wr_en;
  logic [IW-1:0] wr_addr;

  rbdts_sched #(
    .Depth(BufferDepth)
  ) u_sched (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_acc),
    .cmd_i    (cmd),
    .eom_i    (s_axis_tlast_i),
    .res_o    (sres),
    .wr_en_o  (wr_en),
    .wr_addr_o(wr_addr)
  );

  // ring store: one access per item, a push writes at head, a read fetches
  logic              rd_en;
  logic [IW-1:0]     ram_addr;
  logic [BYTE_W-1:0] ram_rdata;

  assign rd_en    = in_acc && (cmd == CMD_READ);
  assign ram_addr = wr_en ? wr_addr : ridx;

  rbdts_ram #(
    .Width(BYTE_W),
    .Depth(BufferDepth)
  ) u_ring_store (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .re_i   (rd_en),
    .addr_i (ram_addr),
    .wdata_i(data_byte),
    .rdata_o(ram_rdata)
  );

  // output register; read data comes straight off the ram's read register
  logic       out_valid_q, out_valid_d;
  logic       rd_flag_q, rd_flag_d;
  sched_res_t res_q, res_d;

  always_comb begin
    out_valid_d = out_valid_q;
    rd_flag_d   = rd_flag_q;
    res_d       = res_q;
    if (in_acc) begin
      out_valid_d = 1'b1;
      rd_flag_d   = (cmd == CMD_READ);
      res_d       = sres;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      rd_flag_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      rd_flag_q   <= rd_flag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  logic [BYTE_W-1:0] read_data;
  assign read_data = rd_flag_q ? ram_rdata : '0;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, read_data, res_q.segment_length,
                            res_q.segment_start, res_q.dma_start, res_q.byte_accepted};

`ifndef SYNTHESIS
  // a started segment is never empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && res_q.dma_start |-> res_q.segment_length != '0)
    else $error("dma start with empty segment");

  // a length is only reported together with a start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && res_q.segment_length != '0 |-> res_q.dma_start)
    else $error("segment length without dma start");

  // an accepted read item shows ram data in the next result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && cmd == CMD_READ |=> rd_flag_q && m_axis_tvalid_o)
    else $error("read item lost its read data");

  // ram write and read never share a cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_en && rd_en))
    else $error("ram write and read collide");
`endif

endmodule
